// ===== design/rc5_pkg.sv =====
// rc5_pkg: shared constants, types and rotate helpers for the rc5 block cipher
// used by rc5_ctrl, rc5_dp and rc5_block_cipher
package rc5_pkg;

    localparam int ROUNDS    = 12;
    localparam int TABLE_LEN = 2 * ROUNDS + 2;
    localparam int ROW_COUNT = ROUNDS + 1;
    localparam int MIX_STEPS = 3 * TABLE_LEN;
    localparam int IDX_W     = $clog2(TABLE_LEN);
    localparam int ROW_W     = IDX_W - 1;
    localparam int STEP_W    = $clog2(MIX_STEPS);
    localparam int WORD_W    = 32;
    localparam int BLOCK_W   = 2 * WORD_W;
    localparam int KEY_W     = 2 * WORD_W;
    localparam int ROT_W     = 5;

    localparam logic [WORD_W-1:0] MAGIC_P   = 32'hB7E1_5163;
    localparam logic [WORD_W-1:0] MAGIC_Q   = 32'h9E37_79B9;
    localparam logic [ROT_W-1:0]  KEY_ROT   = 5'd3;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_MIX_RD,
        ST_MIX_A,
        ST_MIX_B,
        ST_IDLE,
        ST_CRYPT
    } t_state;

    typedef enum logic [1:0] {
        OP_ENC_INIT,
        OP_ENC_ROUND,
        OP_DEC_ROUND,
        OP_DEC_FINAL
    } t_op;

    typedef struct packed {
        logic             key_load;
        logic             fill_we;
        logic             mix_clear;
        logic             mix_a_en;
        logic             mix_b_en;
        logic             key_sel;
        logic [IDX_W-1:0] wr_idx;
        logic [ROW_W-1:0] rd_row;
        logic             rd_bank;
        logic             blk_load;
        logic             step_en;
        logic             out_load;
        t_op              op;
    } t_dp_cmd;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input logic [ROT_W-1:0]  n);
        logic [2*WORD_W-1:0] t;
        t = {x, x} << n;
        return t[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input logic [ROT_W-1:0]  n);
        logic [2*WORD_W-1:0] t;
        t = {x, x} >> n;
        return t[WORD_W-1:0];
    endfunction

endpackage

// ===== design/rc5_block_cipher.sv =====
// rc5_block_cipher: top level of the rc5-32 block cipher with stream ports
// depends on rc5_pkg, rc5_ctrl and rc5_dp
//
// Encrypts (tuser 0) or decrypts (tuser 1) 64-bit words with a 64-bit key,
// bytes little-endian with byte 0 in bit 7..0. A word is accepted in an idle
// cycle and then runs through a single round unit that reads one round key
// pair per cycle from the key table; the result is loaded at the end of the
// last round and the next word is taken the cycle after, so the block
// works on one word at a time while the result of the last one waits in
// the output register. A result that is not taken holds the last round
// until the output register frees up. Writing the key (and leaving reset)
// expands the key table: a fill pass over the table, then a read state and,
// for each mixing step, a MIX_A and a MIX_B state, as the table has a single
// read and write port. s_axis_tready stays low during expansion and in the
// cycle the key is written.
module rc5_block_cipher (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rc5_pkg::KEY_W-1:0]    i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [rc5_pkg::BLOCK_W-1:0]  s_axis_tdata,   // data_in
    input  logic                         s_axis_tuser,   // action
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [rc5_pkg::BLOCK_W-1:0]  m_axis_tdata    // data_out
);

    rc5_pkg::t_dp_cmd cmd;

    rc5_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    rc5_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_key   (i_cfg_wdata),
        .i_blk   (s_axis_tdata),
        .o_blk   (m_axis_tdata)
    );

endmodule

// ===== design/rc5_dp.sv =====
// rc5_dp: round key banks, key expansion mixer and the single round unit
// depends on rc5_pkg, driven by rc5_ctrl through rc5_pkg::t_dp_cmd
module rc5_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rc5_pkg::t_dp_cmd             i_cmd,
    input  logic [rc5_pkg::KEY_W-1:0]    i_key,
    input  logic [rc5_pkg::BLOCK_W-1:0]  i_blk,
    output logic [rc5_pkg::BLOCK_W-1:0]  o_blk
);

    // even and odd round keys, one pair per row
    logic [rc5_pkg::WORD_W-1:0] r_mem_even [rc5_pkg::ROW_COUNT];
    logic [rc5_pkg::WORD_W-1:0] r_mem_odd  [rc5_pkg::ROW_COUNT];
    logic [rc5_pkg::WORD_W-1:0] r_rd_even;
    logic [rc5_pkg::WORD_W-1:0] r_rd_odd;
    logic                       r_rd_bank;

    logic [1:0][rc5_pkg::WORD_W-1:0] r_key_w;
    logic [rc5_pkg::WORD_W-1:0] r_fill_val;
    logic [rc5_pkg::WORD_W-1:0] r_mix_a;
    logic [rc5_pkg::WORD_W-1:0] r_mix_b;
    logic [rc5_pkg::WORD_W-1:0] r_a;
    logic [rc5_pkg::WORD_W-1:0] r_b;
    logic [rc5_pkg::BLOCK_W-1:0] r_out;

    logic [rc5_pkg::WORD_W-1:0] rd_word;
    logic [rc5_pkg::WORD_W-1:0] mix_sum;
    logic [rc5_pkg::WORD_W-1:0] n_mix_a;
    logic [rc5_pkg::WORD_W-1:0] n_mix_b;
    logic [rc5_pkg::WORD_W-1:0] n_a;
    logic [rc5_pkg::WORD_W-1:0] n_b;
    logic [rc5_pkg::WORD_W-1:0] wr_data;
    logic                       mem_we;
    logic [rc5_pkg::ROW_W-1:0]  wr_row;

    assign rd_word = r_rd_bank ? r_rd_odd : r_rd_even;
    assign mix_sum = r_mix_a + r_mix_b;
    assign n_mix_a = rc5_pkg::rotl(rd_word + r_mix_a + r_mix_b, rc5_pkg::KEY_ROT);
    assign n_mix_b = rc5_pkg::rotl(r_key_w[i_cmd.key_sel] + mix_sum,
                                   mix_sum[rc5_pkg::ROT_W-1:0]);
    assign mem_we  = i_cmd.fill_we | i_cmd.mix_a_en;
    assign wr_data = i_cmd.fill_we ? r_fill_val : n_mix_a;
    assign wr_row  = i_cmd.wr_idx[rc5_pkg::IDX_W-1:1];

    // one round per cycle, unless the last round is held for a busy output
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        case (i_cmd.op)
            rc5_pkg::OP_ENC_INIT: begin
                n_a = r_a + r_rd_even;
                n_b = r_b + r_rd_odd;
            end
            rc5_pkg::OP_ENC_ROUND: begin
                n_a = rc5_pkg::rotl(r_a ^ r_b, r_b[rc5_pkg::ROT_W-1:0]) + r_rd_even;
                n_b = rc5_pkg::rotl(r_b ^ n_a, n_a[rc5_pkg::ROT_W-1:0]) + r_rd_odd;
            end
            rc5_pkg::OP_DEC_ROUND: begin
                n_b = rc5_pkg::rotr(r_b - r_rd_odd, r_a[rc5_pkg::ROT_W-1:0]) ^ r_a;
                n_a = rc5_pkg::rotr(r_a - r_rd_even, n_b[rc5_pkg::ROT_W-1:0]) ^ n_b;
            end
            rc5_pkg::OP_DEC_FINAL: begin
                n_a = r_a - r_rd_even;
                n_b = r_b - r_rd_odd;
            end
            default: begin
                n_a = r_a;
                n_b = r_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && !i_cmd.fill_we) begin
            if (i_cmd.wr_idx[0]) begin
                r_mem_odd[wr_row] <= wr_data;
            end else begin
                r_mem_even[wr_row] <= wr_data;
            end
        end else if (i_cmd.fill_we) begin
            if (i_cmd.wr_idx[0]) begin
                r_mem_odd[wr_row] <= wr_data;
            end else begin
                r_mem_even[wr_row] <= wr_data;
            end
        end
        r_rd_even <= r_mem_even[i_cmd.rd_row];
        r_rd_odd  <= r_mem_odd[i_cmd.rd_row];
        r_rd_bank <= i_cmd.rd_bank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_w    <= '0;
            r_fill_val <= rc5_pkg::MAGIC_P;
            r_mix_a    <= '0;
            r_mix_b    <= '0;
        end else begin
            if (i_cmd.key_load) begin
                r_key_w    <= i_key;
                r_fill_val <= rc5_pkg::MAGIC_P;
            end else begin
                if (i_cmd.fill_we) begin
                    r_fill_val <= r_fill_val + rc5_pkg::MAGIC_Q;
                end
                if (i_cmd.mix_b_en) begin
                    r_key_w[i_cmd.key_sel] <= n_mix_b;
                end
            end
            if (i_cmd.mix_clear) begin
                r_mix_a <= '0;
                r_mix_b <= '0;
            end else begin
                if (i_cmd.mix_a_en) begin
                    r_mix_a <= n_mix_a;
                end
                if (i_cmd.mix_b_en) begin
                    r_mix_b <= n_mix_b;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_load) begin
            r_a <= i_blk[rc5_pkg::WORD_W-1:0];
            r_b <= i_blk[rc5_pkg::BLOCK_W-1:rc5_pkg::WORD_W];
        end else if (i_cmd.step_en) begin
            r_a <= n_a;
            r_b <= n_b;
        end
        if (i_cmd.out_load) begin
            r_out <= {n_b, n_a};
        end
    end

    assign o_blk = r_out;

endmodule

// ===== design/rc5_ctrl.sv =====
// rc5_ctrl: sequencer for key fill, key mixing and block rounds
// depends on rc5_pkg, drives rc5_dp through rc5_pkg::t_dp_cmd
module rc5_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_in_valid,
    input  logic             i_in_action,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output rc5_pkg::t_dp_cmd o_cmd
);

    rc5_pkg::t_state r_state;
    rc5_pkg::t_state n_state;

    logic [rc5_pkg::IDX_W-1:0]  r_idx;
    logic [rc5_pkg::IDX_W-1:0]  n_idx;
    logic [rc5_pkg::STEP_W-1:0] r_step;
    logic [rc5_pkg::STEP_W-1:0] n_step;
    logic [rc5_pkg::ROW_W-1:0]  r_row;
    logic [rc5_pkg::ROW_W-1:0]  n_row;
    logic                       r_action;
    logic                       n_action;
    logic                       r_out_valid;
    logic                       n_out_valid;

    logic                       idx_last;
    logic                       step_last;
    logic [rc5_pkg::IDX_W-1:0]  idx_wrap;
    logic                       in_acc;
    logic                       crypt_last;
    logic                       out_free;
    logic [rc5_pkg::ROW_W-1:0]  row_next;
    logic [rc5_pkg::ROW_W-1:0]  row_first;

    assign idx_last   = (r_idx == rc5_pkg::IDX_W'(rc5_pkg::TABLE_LEN - 1));
    assign step_last  = (r_step == rc5_pkg::STEP_W'(rc5_pkg::MIX_STEPS - 1));
    assign idx_wrap   = idx_last ? '0 : r_idx + rc5_pkg::IDX_W'(1);
    assign in_acc     = i_in_valid && (r_state == rc5_pkg::ST_IDLE) && !i_cfg_we;
    assign out_free   = !r_out_valid || i_out_ready;
    assign crypt_last = r_action ? (r_row == '0)
                                 : (r_row == rc5_pkg::ROW_W'(rc5_pkg::ROUNDS));
    assign row_next   = r_action ? r_row - rc5_pkg::ROW_W'(1)
                                 : r_row + rc5_pkg::ROW_W'(1);
    assign row_first  = i_in_action ? rc5_pkg::ROW_W'(rc5_pkg::ROUNDS) : '0;

    // next state
    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = rc5_pkg::ST_FILL;
        end else begin
            case (r_state)
                rc5_pkg::ST_FILL:   n_state = idx_last ? rc5_pkg::ST_MIX_RD : rc5_pkg::ST_FILL;
                rc5_pkg::ST_MIX_RD: n_state = rc5_pkg::ST_MIX_A;
                rc5_pkg::ST_MIX_A:  n_state = rc5_pkg::ST_MIX_B;
                rc5_pkg::ST_MIX_B:  n_state = step_last ? rc5_pkg::ST_IDLE : rc5_pkg::ST_MIX_A;
                rc5_pkg::ST_IDLE:   n_state = in_acc ? rc5_pkg::ST_CRYPT : rc5_pkg::ST_IDLE;
                rc5_pkg::ST_CRYPT: begin
                    n_state = (crypt_last && out_free) ? rc5_pkg::ST_IDLE : rc5_pkg::ST_CRYPT;
                end
                default:            n_state = rc5_pkg::ST_FILL;
            endcase
        end
    end

    // counters and block flags
    always_comb begin
        n_idx    = r_idx;
        n_step   = r_step;
        n_row    = r_row;
        n_action = r_action;
        if (i_cfg_we) begin
            n_idx  = '0;
            n_step = '0;
        end else begin
            case (r_state)
                rc5_pkg::ST_FILL: begin
                    n_idx  = idx_wrap;
                    n_step = '0;
                end
                rc5_pkg::ST_MIX_B: begin
                    n_idx  = idx_wrap;
                    n_step = step_last ? '0 : r_step + rc5_pkg::STEP_W'(1);
                end
                rc5_pkg::ST_IDLE: begin
                    if (in_acc) begin
                        n_action = i_in_action;
                        n_row    = row_first;
                    end
                end
                rc5_pkg::ST_CRYPT: begin
                    if (!crypt_last) begin
                        n_row = row_next;
                    end
                end
                default: begin
                    n_idx = r_idx;
                end
            endcase
        end
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.key_load = i_cfg_we;
        o_cmd.key_sel  = r_step[0];
        o_cmd.wr_idx   = r_idx;
        o_cmd.rd_row   = r_idx[rc5_pkg::IDX_W-1:1];
        o_cmd.rd_bank  = r_idx[0];
        o_cmd.op       = r_action ? ((r_row == '0) ? rc5_pkg::OP_DEC_FINAL
                                                    : rc5_pkg::OP_DEC_ROUND)
                                  : ((r_row == '0) ? rc5_pkg::OP_ENC_INIT
                                                    : rc5_pkg::OP_ENC_ROUND);
        case (r_state)
            rc5_pkg::ST_FILL: begin
                o_cmd.fill_we   = 1'b1;
                o_cmd.mix_clear = idx_last;
            end
            rc5_pkg::ST_MIX_RD: begin
                o_cmd.rd_bank = r_idx[0];
            end
            rc5_pkg::ST_MIX_A: begin
                o_cmd.mix_a_en = 1'b1;
            end
            rc5_pkg::ST_MIX_B: begin
                o_cmd.mix_b_en = 1'b1;
                o_cmd.rd_row   = idx_wrap[rc5_pkg::IDX_W-1:1];
                o_cmd.rd_bank  = idx_wrap[0];
            end
            rc5_pkg::ST_IDLE: begin
                o_cmd.rd_row   = row_first;
                o_cmd.blk_load = in_acc;
            end
            rc5_pkg::ST_CRYPT: begin
                if (crypt_last) begin
                    o_cmd.rd_row   = r_row;
                    o_cmd.out_load = out_free;
                end else begin
                    o_cmd.rd_row  = row_next;
                    o_cmd.step_en = 1'b1;
                end
            end
            default: begin
                o_cmd.fill_we = 1'b0;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rc5_pkg::ST_FILL;
            r_idx       <= '0;
            r_step      <= '0;
            r_row       <= '0;
            r_action    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_step      <= n_step;
            r_row       <= n_row;
            r_action    <= n_action;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == rc5_pkg::ST_IDLE) && !i_cfg_we;
    assign o_out_valid = r_out_valid;

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result word loaded over an untaken result");

    a_accept_starts_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_cfg_we) |=> (r_state == rc5_pkg::ST_CRYPT))
        else $error("accepted word did not start the rounds");

    a_mix_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc5_pkg::ST_MIX_B && step_last && !i_cfg_we)
            |=> (r_state == rc5_pkg::ST_IDLE && r_idx == '0))
        else $error("key mixing did not end at table start");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc5_pkg::ST_CRYPT) |-> (r_row <= rc5_pkg::ROW_W'(rc5_pkg::ROUNDS)))
        else $error("round row out of range");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= rc5_pkg::IDX_W'(rc5_pkg::TABLE_LEN - 1))
        else $error("key index out of range");

endmodule

// ===== verif/tb_rc5_block_cipher.sv =====
// tb_rc5_block_cipher: self-checking stream testbench for the rc5-32/12/8 block cipher
// depends on rc5_pkg and rc5_block_cipher; predicts key expansion and both cipher directions
module tb_rc5_block_cipher;

    typedef enum logic {
        ACT_ENCRYPT = 1'b0,
        ACT_DECRYPT = 1'b1
    } t_action;

    typedef enum logic {
        ROW_PLAIN,
        ROW_ZERO_ROT
    } t_row_kind;

    typedef struct packed {
        logic [rc5_pkg::KEY_W-1:0]   key;
        t_action                     act;
        logic [rc5_pkg::BLOCK_W-1:0] data;
        t_row_kind                   kind;
    } t_dir_row;

    localparam int DIR_COUNT      = 21;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 230;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam logic [63:0] ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [rc5_pkg::KEY_W-1:0]     i_cfg_wdata;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [rc5_pkg::BLOCK_W-1:0]   s_axis_tdata;   // data_in
    logic                          s_axis_tuser;   // action
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [rc5_pkg::BLOCK_W-1:0]   m_axis_tdata;   // data_out

    logic [rc5_pkg::WORD_W-1:0]    rk_tbl [rc5_pkg::TABLE_LEN];
    logic [rc5_pkg::BLOCK_W-1:0]   cipher_out_q [$];
    logic [rc5_pkg::KEY_W-1:0]     cur_key;
    logic                          tx_idle_on;
    logic                          rx_idle_on;
    logic                          rx_hold_req;
    int                            err_count;
    int                            words_sent;
    int                            enc_count;
    int                            dec_count;
    int                            key_loads;
    int                            results_seen;
    int                            stall_cycles;

    t_dir_row dir_rows [DIR_COUNT] = '{
        '{64'h0, ACT_ENCRYPT, 64'h0, ROW_PLAIN},
        '{64'h0, ACT_ENCRYPT, ONES, ROW_PLAIN},
        '{64'h0, ACT_DECRYPT, 64'h0, ROW_PLAIN},
        '{64'h0, ACT_DECRYPT, ONES, ROW_PLAIN},
        '{64'h0, ACT_ENCRYPT, 64'h0000_0000_FFFF_FFFF, ROW_PLAIN},
        '{64'h0, ACT_DECRYPT, 64'hFFFF_FFFF_0000_0000, ROW_PLAIN},
        '{64'h0, ACT_ENCRYPT, 64'hAAAA_AAAA_5555_5555, ROW_PLAIN},
        '{64'h0, ACT_DECRYPT, 64'h5555_5555_AAAA_AAAA, ROW_PLAIN},
        '{64'h0, ACT_ENCRYPT, 64'h1234_5678_9ABC_DEF0, ROW_ZERO_ROT},
        '{64'h0, ACT_DECRYPT, 64'h0FED_CBA9_8765_4321, ROW_ZERO_ROT},
        '{ONES, ACT_ENCRYPT, 64'h0, ROW_PLAIN},
        '{ONES, ACT_DECRYPT, ONES, ROW_PLAIN},
        '{ONES, ACT_ENCRYPT, 64'h0123_4567_89AB_CDEF, ROW_PLAIN},
        '{ONES, ACT_DECRYPT, 64'h8000_0000_0000_0001, ROW_ZERO_ROT},
        '{64'h0123_4567_89AB_CDEF, ACT_ENCRYPT, 64'h8000_0000_0000_0001, ROW_PLAIN},
        '{64'h0123_4567_89AB_CDEF, ACT_DECRYPT, 64'h0000_0001_8000_0000, ROW_PLAIN},
        '{64'h0123_4567_89AB_CDEF, ACT_ENCRYPT, 64'hFEDC_BA98_7654_3210, ROW_ZERO_ROT},
        '{64'h8000_0000_0000_0001, ACT_ENCRYPT, 64'hDEAD_BEEF_CAFE_F00D, ROW_PLAIN},
        '{64'h8000_0000_0000_0001, ACT_DECRYPT, 64'hDEAD_BEEF_CAFE_F00D, ROW_PLAIN},
        '{64'h0000_0000_0000_0001, ACT_ENCRYPT, 64'h0, ROW_PLAIN},
        '{64'h0000_0000_0000_0001, ACT_DECRYPT, 64'h0, ROW_PLAIN}
    };

    rc5_block_cipher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [rc5_pkg::WORD_W-1:0] rol32(
        input logic [rc5_pkg::WORD_W-1:0] x,
        input logic [4:0]                 n);
        return (x << n) | (x >> (6'd32 - n));
    endfunction

    function automatic logic [rc5_pkg::WORD_W-1:0] ror32(
        input logic [rc5_pkg::WORD_W-1:0] x,
        input logic [4:0]                 n);
        return (x >> n) | (x << (6'd32 - n));
    endfunction

    task automatic expand_round_keys(input logic [rc5_pkg::KEY_W-1:0] key);
        logic [rc5_pkg::WORD_W-1:0] kw [2];
        logic [rc5_pkg::WORD_W-1:0] ma;
        logic [rc5_pkg::WORD_W-1:0] mb;
        logic [rc5_pkg::WORD_W-1:0] sum;
        int ti;
        int ki;
        kw[0] = key[31:0];
        kw[1] = key[63:32];
        rk_tbl[0] = rc5_pkg::MAGIC_P;
        for (int t = 1; t < rc5_pkg::TABLE_LEN; t++)
            rk_tbl[t] = rk_tbl[t-1] + rc5_pkg::MAGIC_Q;
        ma = '0;
        mb = '0;
        ti = 0;
        ki = 0;
        for (int t = 0; t < rc5_pkg::MIX_STEPS; t++) begin
            ma = rol32(rk_tbl[ti] + ma + mb, rc5_pkg::KEY_ROT);
            rk_tbl[ti] = ma;
            sum = ma + mb;
            mb = rol32(kw[ki] + sum, sum[4:0]);
            kw[ki] = mb;
            ti = (ti + 1) % rc5_pkg::TABLE_LEN;
            ki = ki ^ 1;
        end
    endtask

    function automatic logic [rc5_pkg::BLOCK_W-1:0] rc5_crypt(
        input t_action                     act,
        input logic [rc5_pkg::BLOCK_W-1:0] blk);
        logic [rc5_pkg::WORD_W-1:0] a;
        logic [rc5_pkg::WORD_W-1:0] b;
        a = blk[31:0];
        b = blk[63:32];
        if (act == ACT_ENCRYPT) begin
            a = a + rk_tbl[0];
            b = b + rk_tbl[1];
            for (int r = 1; r <= rc5_pkg::ROUNDS; r++) begin
                a = rol32(a ^ b, b[4:0]) + rk_tbl[2*r];
                b = rol32(b ^ a, a[4:0]) + rk_tbl[2*r+1];
            end
        end else begin
            for (int r = rc5_pkg::ROUNDS; r >= 1; r--) begin
                b = ror32(b - rk_tbl[2*r+1], a[4:0]) ^ a;
                a = ror32(a - rk_tbl[2*r], b[4:0]) ^ b;
            end
            b = b - rk_tbl[1];
            a = a - rk_tbl[0];
        end
        return {b, a};
    endfunction

    // first data-dependent rotation of the block comes out as zero
    function automatic logic [rc5_pkg::BLOCK_W-1:0] zero_rot_block(
        input t_action                     act,
        input logic [rc5_pkg::BLOCK_W-1:0] seed);
        logic [rc5_pkg::WORD_W-1:0] nb;
        nb = ~rk_tbl[1] + 1'b1;
        if (act == ACT_ENCRYPT)
            return {nb, seed[31:0]};
        return {seed[63:32], seed[31:5], 5'b0};
    endfunction

    // entered and left at a falling edge
    task automatic send_block(input t_action act, input logic [rc5_pkg::BLOCK_W-1:0] blk);
        int gap;
        if (tx_idle_on && $urandom_range(99) < 24) begin
            gap = $urandom_range(1, 20);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= blk;
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        cipher_out_q.push_back(rc5_crypt(act, blk));
        words_sent++;
        if (act == ACT_ENCRYPT)
            enc_count++;
        else
            dec_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (cipher_out_q.size() != 0 || !s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_key(input logic [rc5_pkg::KEY_W-1:0] key);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= key;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        expand_round_keys(key);
        cur_key = key;
        key_loads++;
    endtask

    // result side: random stalls, plus a long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            m_axis_tready <= !(rx_idle_on && $urandom_range(99) < 24);
        end
    end

    always @(posedge i_clk) begin
        logic [rc5_pkg::BLOCK_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (cipher_out_q.size() == 0) begin
                $error("unexpected word: data_out %h", m_axis_tdata);
                err_count++;
            end else begin
                want = cipher_out_q.pop_front();
                if (m_axis_tdata !== want) begin
                    $error("data_out mismatch: expected %h actual %h", want, m_axis_tdata);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [rc5_pkg::BLOCK_W-1:0] blk;
        logic [rc5_pkg::BLOCK_W-1:0] ctext;
        t_action act;
        int sel;
        int sent_in_phase;
        logic hold_done;
        logic drain_done;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        rx_hold_req   = 1'b0;
        hold_done     = 1'b0;
        drain_done    = 1'b0;
        err_count     = 0;
        words_sent    = 0;
        enc_count     = 0;
        dec_count     = 0;
        key_loads     = 0;
        results_seen  = 0;
        stall_cycles  = 0;
        cur_key       = '0;
        expand_round_keys('0);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows, predictor checked
        for (int i = 0; i < DIR_COUNT; i++) begin
            if (dir_rows[i].key != cur_key)
                load_key(dir_rows[i].key);
            blk = dir_rows[i].data;
            if (dir_rows[i].kind == ROW_ZERO_ROT)
                blk = zero_rot_block(dir_rows[i].act, blk);
            send_block(dir_rows[i].act, blk);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1)
                load_key('0);
            else
                load_key({$urandom, $urandom});
            tx_idle_on = (p != 3);
            rx_idle_on = (p != 3);
            sent_in_phase = 0;
            while (sent_in_phase < PHASE_ITEMS) begin
                if (p == 5 && sent_in_phase >= 40 && !hold_done) begin
                    rx_hold_req = 1'b1;
                    hold_done   = 1'b1;
                end
                if (p == 2 && sent_in_phase >= 115 && !drain_done) begin
                    wait_drained();
                    drain_done = 1'b1;
                end
                sel = $urandom_range(9);
                act = t_action'($urandom_range(1));
                blk = {$urandom, $urandom};
                if (sel == 0) begin
                    send_block(act, zero_rot_block(act, blk));
                    sent_in_phase++;
                end else if (sel == 1) begin
                    blk = 64'h1 << $urandom_range(63);
                    if ($urandom_range(1))
                        blk = ~blk;
                    send_block(act, blk);
                    sent_in_phase++;
                end else if (sel <= 3) begin
                    // encrypt then decrypt the ciphertext back
                    ctext = rc5_crypt(ACT_ENCRYPT, blk);
                    send_block(ACT_ENCRYPT, blk);
                    send_block(ACT_DECRYPT, ctext);
                    sent_in_phase += 2;
                end else begin
                    send_block(act, blk);
                    sent_in_phase++;
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d words (%0d encrypt, %0d decrypt), checked %0d results",
                 words_sent, enc_count, dec_count, results_seen);
        $display("over %0d key loads, with random stalls and a long output hold-off",
                 key_loads);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
